// ===== src/ataid_pkg.sv =====
// ataid_pkg: shared types, word offsets and helpers for the ATA IDENTIFY parser.
// No dependencies; imported by ataid_capture and ata_identify_block_parser_top.
package ataid_pkg;

	localparam int BLOCK_WORDS_DEF = 256;
	localparam int IDX_W           = 8;

	// IDENTIFY word offsets that are captured
	localparam logic [IDX_W-1:0] W_GEN_CONFIG = 8'd0;
	localparam logic [IDX_W-1:0] W_CAPS       = 8'd49;
	localparam logic [IDX_W-1:0] W_LBA28_LO   = 8'd60;
	localparam logic [IDX_W-1:0] W_LBA28_HI   = 8'd61;
	localparam logic [IDX_W-1:0] W_MWDMA      = 8'd63;
	localparam logic [IDX_W-1:0] W_SATA_CAPS  = 8'd76;
	localparam logic [IDX_W-1:0] W_CMDSET_LO  = 8'd82;
	localparam logic [IDX_W-1:0] W_CMDSET_HI  = 8'd83;
	localparam logic [IDX_W-1:0] W_UDMA       = 8'd88;
	localparam logic [IDX_W-1:0] W_HW_RESET   = 8'd93;
	localparam logic [IDX_W-1:0] W_LBA48_0    = 8'd100;
	localparam logic [IDX_W-1:0] W_LBA48_1    = 8'd101;
	localparam logic [IDX_W-1:0] W_LBA48_2    = 8'd102;
	localparam logic [IDX_W-1:0] W_LBA48_3    = 8'd103;
	localparam logic [IDX_W-1:0] W_DSM        = 8'd169;

	// register map (word address = paddr[2])
	localparam logic REG_UDMA_BASE  = 1'b0;
	localparam logic REG_MWDMA_BASE = 1'b1;
	localparam logic [7:0] UDMA_BASE_RST  = 8'd64;
	localparam logic [7:0] MWDMA_BASE_RST = 8'd32;

	typedef enum logic [1:0] {
		DMA_NONE  = 2'd0,
		DMA_UDMA  = 2'd1,
		DMA_MWDMA = 2'd2
	} dma_kind_t;

	// captured IDENTIFY state, carried from capture to result logic
	typedef struct packed {
		logic [15:0] gen_config;
		logic [15:0] caps;
		logic [31:0] lba28;
		logic [15:0] mwdma;
		logic [15:0] cmdset_lo;
		logic [15:0] cmdset_hi;
		logic [15:0] udma;
		logic        ncq;
		logic        cable80;
		logic        trim;
		logic [63:0] lba48;
		logic        kind;
		logic        channel;
		logic        drive;
	} ident_t;

	typedef struct packed {
		logic       found;
		logic [2:0] pos;
	} top_bit_t;

	// highest set bit of an 8-bit mask
	function automatic top_bit_t top_bit(input logic [7:0] m);
		top_bit_t r;
		r = '0;
		for (int b = 0; b < 8; b++) begin
			if (m[b]) begin
				r.found = 1'b1;
				r.pos   = 3'(b);
			end
		end
		return r;
	endfunction

endpackage

// ===== src/ata_identify_block_parser_top.sv =====
// ata_identify_block_parser_top: ATA IDENTIFY block parser, stream in, one summary beat out.
// Depends on ataid_pkg and ataid_capture.
//
// Usage: feed the IDENTIFY block one 16-bit word per beat on the s_ side, in word order,
// with first_word set on word 0 (after reset, or after a complete block, the next word is
// word 0 anyway; first_word mid-block abandons the block with no result). Word 0 also
// latches device kind, channel and drive. After word BLOCK_WORDS-1 one summary beat comes
// out on the m_ side: signature, capabilities, command sets, feature flags, sector count
// (48-bit words only when word 83 carries the 01 validity pattern and LBA48 is set; zero
// for packet devices or 2^48 and above), DMA mode masks (UDMA capped at mode 2 without an
// 80-wire cable), DMA kind and the chosen transfer-mode code. Throughput is one word per
// clock while s_tready is high. The summary is built from the capture registers in the cycle
// after the last word and is loaded once the output register is free; s_tready is low only
// while that summary waits and the previous one still sits unclaimed on the m_ side.
// Write the two mode-base registers over APB only while no block is in flight (not enforced).
module ata_identify_block_parser_top #(
	parameter int BLOCK_WORDS = ataid_pkg::BLOCK_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] id_word
	input  logic [3:0]   s_tuser,   // [0] first_word, [1] device_kind, [2] channel_num,
	                                // [3] drive_num
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // [15:0] signature, [31:16] capabilities,
	                                // [63:32] cmd_sets, [68:64] feat_flags,
	                                // [116:69] sector_count, [124:117] mw_modes,
	                                // [131:125] ud_modes, [133:132] dma_kind,
	                                // [141:134] transfer_mode, [142] mode_found,
	                                // [143] channel_out, [144] drive_out, [151:145] zero
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import ataid_pkg::*;

	logic [7:0] udma_base_q;
	logic [7:0] mwdma_base_q;

	logic       in_beat;
	logic       last_word;
	ident_t     ident;
	logic       emit_s1;    // capture registers hold a finished block
	logic       load_out;

	logic         m_tvalid_q;
	logic [151:0] m_tdata_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			udma_base_q  <= UDMA_BASE_RST;
			mwdma_base_q <= MWDMA_BASE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_UDMA_BASE:  udma_base_q  <= pwdata[7:0];
				REG_MWDMA_BASE: mwdma_base_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UDMA_BASE:  prdata = {24'd0, udma_base_q};
			REG_MWDMA_BASE: prdata = {24'd0, mwdma_base_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- capture ----------------
	// the result register can take a summary when empty or being drained
	assign load_out = emit_s1 && (!m_tvalid_q || m_tready);
	// hold words off only while a finished block cannot move to the output yet,
	// since the next block's word 0 would overwrite its capture registers
	assign s_tready = !emit_s1 || load_out;
	assign in_beat  = s_tvalid && s_tready;

	ataid_capture #(
		.BLOCK_WORDS(BLOCK_WORDS)
	) u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (in_beat),
		.id_word     (s_tdata),
		.first_word  (s_tuser[0]),
		.device_kind (s_tuser[1]),
		.channel_num (s_tuser[2]),
		.drive_num   (s_tuser[3]),
		.last_word   (last_word),
		.ident       (ident)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
		end else if (in_beat) begin
			emit_s1 <= last_word;
		end else if (load_out) begin
			emit_s1 <= 1'b0;
		end
	end

	// ---------------- summary logic ----------------
	logic [4:0]  flags;
	logic        lba48_ok;
	logic [63:0] sectors_raw;
	logic [47:0] sectors;
	logic [7:0]  mw_modes;
	logic [6:0]  ud_modes;
	top_bit_t    ud_top;
	top_bit_t    mw_top;
	dma_kind_t   dma_kind;
	logic [7:0]  xfer_mode;
	logic        mode_found;

	always_comb begin
		flags[0] = ident.caps[8] || (ident.mwdma != '0) || (ident.udma != '0);
		flags[1] = ident.cmdset_lo[0];
		flags[2] = ident.cmdset_hi[10];
		flags[3] = ident.ncq;
		flags[4] = ident.trim;

		// 48-bit capacity words count only with LBA48 set and word 83 bits 15:14 == 01
		lba48_ok    = flags[2] && (ident.cmdset_hi[15:14] == 2'b01);
		sectors_raw = lba48_ok ? ident.lba48 : {32'd0, ident.lba28};
		if (ident.kind || (sectors_raw[63:48] != '0))
			sectors = '0;
		else
			sectors = sectors_raw[47:0];

		mw_modes = ident.mwdma[7:0];
		ud_modes = ident.cable80 ? ident.udma[6:0] : {4'd0, ident.udma[2:0]};

		if (ud_modes != '0)
			dma_kind = DMA_UDMA;
		else if (mw_modes != '0)
			dma_kind = DMA_MWDMA;
		else
			dma_kind = DMA_NONE;

		// UDMA wins over multiword DMA; code is base plus top mode, wrapping at 8 bits
		ud_top = top_bit({1'b0, ud_modes});
		mw_top = top_bit(mw_modes);
		if (ud_top.found) begin
			xfer_mode  = udma_base_q + {5'd0, ud_top.pos};
			mode_found = 1'b1;
		end else if (mw_top.found) begin
			xfer_mode  = mwdma_base_q + {5'd0, mw_top.pos};
			mode_found = 1'b1;
		end else begin
			xfer_mode  = '0;
			mode_found = 1'b0;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {7'd0, ident.drive, ident.channel, mode_found, xfer_mode,
			              dma_kind, ud_modes, mw_modes, sectors, flags,
			              ident.cmdset_hi, ident.cmdset_lo, ident.caps, ident.gen_config};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== src/ataid_capture.sv =====
// ataid_capture: word counter and capture registers for the IDENTIFY words of interest.
// Depends on ataid_pkg.
module ataid_capture #(
	parameter int BLOCK_WORDS = ataid_pkg::BLOCK_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat,
	input  logic [15:0]         id_word,
	input  logic                first_word,
	input  logic                device_kind,
	input  logic                channel_num,
	input  logic                drive_num,
	output logic                last_word,
	output ataid_pkg::ident_t   ident
);
	import ataid_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_WORDS - 1);

	logic [IDX_W-1:0] word_index_q;
	logic [IDX_W-1:0] cur_idx;
	ident_t           ident_q;

	assign cur_idx   = first_word ? '0 : word_index_q;
	assign last_word = (cur_idx == LAST_IDX);
	assign ident     = ident_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= '0;
			ident_q      <= '0;
		end else if (beat) begin
			word_index_q <= last_word ? '0 : cur_idx + 1'b1;
			case (cur_idx)
				W_GEN_CONFIG: begin
					ident_q.gen_config <= id_word;
					ident_q.kind       <= device_kind;
					ident_q.channel    <= channel_num;
					ident_q.drive      <= drive_num;
				end
				W_CAPS:      ident_q.caps         <= id_word;
				W_LBA28_LO:  ident_q.lba28[15:0]  <= id_word;
				W_LBA28_HI:  ident_q.lba28[31:16] <= id_word;
				W_MWDMA:     ident_q.mwdma        <= id_word;
				W_SATA_CAPS: ident_q.ncq          <= id_word[8];
				W_CMDSET_LO: ident_q.cmdset_lo    <= id_word;
				W_CMDSET_HI: ident_q.cmdset_hi    <= id_word;
				W_UDMA:      ident_q.udma         <= id_word;
				W_HW_RESET:  ident_q.cable80      <= id_word[13];
				W_LBA48_0:   ident_q.lba48[15:0]  <= id_word;
				W_LBA48_1:   ident_q.lba48[31:16] <= id_word;
				W_LBA48_2:   ident_q.lba48[47:32] <= id_word;
				W_LBA48_3:   ident_q.lba48[63:48] <= id_word;
				W_DSM:       ident_q.trim         <= id_word[0];
				default: ;
			endcase
		end
	end

endmodule
